// File: rtl/kms_pkg.sv
`default_nettype none

package kms_pkg;

   localparam int COL_W  = 4;
   localparam int ROW_W  = 6;
   localparam int BYTE_W = 8;
   localparam int PTR_W  = 5;

   // request codes
   localparam logic [1:0] REQ_SAMPLE = 2'd0;
   localparam logic [1:0] REQ_READ   = 2'd1;
   localparam logic [1:0] REQ_STOP   = 2'd2;

   // register map
   localparam logic [PTR_W-1:0]  REG_COUNT  = 5'd16;
   localparam logic [COL_W-1:0]  ADDR_ID0   = 4'd0;
   localparam logic [COL_W-1:0]  ADDR_ID1   = 4'd1;
   localparam logic [COL_W-1:0]  ADDR_RSV0  = 4'd2;
   localparam logic [COL_W-1:0]  ADDR_RSV1  = 4'd3;
   localparam logic [COL_W-1:0]  SNAP_BASE  = 4'd4;
   localparam logic [BYTE_W-1:0] ID0_BYTE   = 8'haa;
   localparam logic [BYTE_W-1:0] ID1_BYTE   = 8'h55;
   localparam logic [BYTE_W-1:0] PAST_BYTE  = 8'hff;

   // bootloader key combination: (column, row) pairs
   localparam int BOOT_COL_A = 0;
   localparam int BOOT_ROW_A = 2;
   localparam int BOOT_COL_B = 2;
   localparam int BOOT_ROW_B = 5;
   localparam int BOOT_COL_C = 4;
   localparam int BOOT_ROW_C = 2;

   typedef struct packed {
      logic             done;
      logic             change;
      logic             boot;
      logic [ROW_W-1:0] active;
   } scan_result_type;

endpackage

`default_nettype wire

// File: rtl/kms_scan.sv
`default_nettype none

module kms_scan
   import kms_pkg::*;
#(
   parameter int NUM_COLUMNS = 12
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              sample,
   input  wire logic [COL_W-1:0]  col,
   input  wire logic [ROW_W-1:0]  levels,
   input  wire logic [COL_W-1:0]  rd_index,
   output logic [ROW_W-1:0]       rd_row,
   output scan_result_type        result
);

   logic [ROW_W-1:0] scan_ff [NUM_COLUMNS];
   logic [ROW_W-1:0] scan_in [NUM_COLUMNS];
   logic [ROW_W-1:0] snap_ff [NUM_COLUMNS];
   logic [ROW_W-1:0] acc_ff;
   logic [ROW_W-1:0] acc_in;
   logic [ROW_W-1:0] pressed;
   logic             in_range;
   logic             last_col;
   logic             boot;
   logic             differ;

   assign pressed  = ~levels;
   assign in_range = col < COL_W'(NUM_COLUMNS);
   assign last_col = col == COL_W'(NUM_COLUMNS - 1);
   assign acc_in   = acc_ff | pressed;

   always_comb begin
      differ = 1'b0;
      rd_row = '0;
      for (int i = 0; i < NUM_COLUMNS; i++) begin
         scan_in[i] = (col == COL_W'(i)) ? pressed : scan_ff[i];
         if (scan_in[i] != snap_ff[i]) begin
            differ = 1'b1;
         end
         if (rd_index == COL_W'(i)) begin
            rd_row = snap_ff[i];
         end
      end
   end

   assign boot = scan_in[BOOT_COL_A][BOOT_ROW_A] && scan_in[BOOT_COL_B][BOOT_ROW_B] &&
                 scan_in[BOOT_COL_C][BOOT_ROW_C];

   always_comb begin
      result = '0;
      if (sample && in_range && last_col) begin
         result.done   = 1'b1;
         result.active = acc_in;
         result.boot   = boot;
         result.change = !boot && differ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         for (int i = 0; i < NUM_COLUMNS; i++) begin
            scan_ff[i] <= '0;
            snap_ff[i] <= '0;
         end
      end else if (advance && sample && in_range) begin
         scan_ff <= scan_in;
         if (last_col) begin
            acc_ff <= '0;
            // combo seen: snapshot stays as it was
            if (!boot && differ) begin
               snap_ff <= scan_in;
            end
         end else begin
            acc_ff <= acc_in;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/kms_regs.sv
`default_nettype none

module kms_regs
   import kms_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              read_req,
   input  wire logic              stop_req,
   input  wire logic [ROW_W-1:0]  snap_row,
   output logic [COL_W-1:0]       snap_index,
   output logic [BYTE_W-1:0]      read_byte
);

   logic [PTR_W-1:0] ptr_ff;
   logic             in_map;
   logic [BYTE_W-1:0] map_byte;

   assign in_map     = ptr_ff < REG_COUNT;
   assign snap_index = ptr_ff[COL_W-1:0] - SNAP_BASE;

   always_comb begin
      case (ptr_ff[COL_W-1:0])
         ADDR_ID0:             map_byte = ID0_BYTE;
         ADDR_ID1:             map_byte = ID1_BYTE;
         ADDR_RSV0, ADDR_RSV1: map_byte = '0;
         default:              map_byte = {{(BYTE_W-ROW_W){1'b0}}, snap_row};
      endcase
   end

   always_comb begin
      read_byte = '0;
      if (read_req) begin
         read_byte = in_map ? map_byte : PAST_BYTE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else if (advance) begin
         // pointer saturates once past the map
         if (read_req && in_map) begin
            ptr_ff <= ptr_ff + PTR_W'(1);
         end else if (stop_req) begin
            ptr_ff <= '0;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/key_matrix_scan_register_bank.sv
`default_nettype none

// Keyboard matrix scanner with a bus-readable register bank. Each request word is
// a column sample, a bus read byte or a bus stop; each gives exactly one response
// word. Words pass an input register and then a result register; one request
// is taken every cycle while the response side does not stall. That rate is set
// by the scan buffer, snapshot and read pointer, which are flops updated as each
// request advances. Snapshot compare, copy and bootloader combo check all happen
// on the sample of the last column (NUM_COLUMNS-1). Registers 0/1 read 0xaa/0x55,
// 2-3 read 0, 4-15 read the key snapshot, and reads past 15 return 0xff until
// a stop.
module key_matrix_scan_register_bank
   import kms_pkg::*;
#(
   parameter int NUM_COLUMNS = 12
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_type,
   input  wire logic [COL_W-1:0]  req_column_index,
   input  wire logic [ROW_W-1:0]  req_row_levels,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [BYTE_W-1:0]      rsp_read_data,
   output logic                   rsp_scan_done,
   output logic                   rsp_key_change,
   output logic                   rsp_enter_bootloader,
   output logic [ROW_W-1:0]       rsp_pressed_rows
);

   logic              in_valid_ff;
   logic [1:0]        in_type_ff;
   logic [COL_W-1:0]  in_col_ff;
   logic [ROW_W-1:0]  in_rows_ff;
   logic              out_valid_ff;
   logic [BYTE_W-1:0] out_data_ff;
   scan_result_type   out_scan_ff;

   logic              advance;
   logic              accept;
   logic              sample;
   logic              read_req;
   logic              stop_req;
   logic [COL_W-1:0]  snap_index;
   logic [ROW_W-1:0]  snap_row;
   logic [BYTE_W-1:0] read_byte;
   scan_result_type   scan_result;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign sample   = in_type_ff == REQ_SAMPLE;
   assign read_req = in_type_ff == REQ_READ;
   assign stop_req = in_type_ff == REQ_STOP;

   kms_scan #(
      .NUM_COLUMNS (NUM_COLUMNS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .sample   (sample),
      .col      (in_col_ff),
      .levels   (in_rows_ff),
      .rd_index (snap_index),
      .rd_row   (snap_row),
      .result   (scan_result)
   );

   kms_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .read_req   (read_req),
      .stop_req   (stop_req),
      .snap_row   (snap_row),
      .snap_index (snap_index),
      .read_byte  (read_byte)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_type_ff <= req_type;
         in_col_ff  <= req_column_index;
         in_rows_ff <= req_row_levels;
      end
      if (advance) begin
         out_data_ff <= read_byte;
         out_scan_ff <= scan_result;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_read_data        = out_data_ff;
   assign rsp_scan_done        = out_scan_ff.done;
   assign rsp_key_change       = out_scan_ff.change;
   assign rsp_enter_bootloader = out_scan_ff.boot;
   assign rsp_pressed_rows     = out_scan_ff.active;

endmodule

`default_nettype wire

// File: rtl/kms_checker.sv
`default_nettype none

module kms_checker
   import kms_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [BYTE_W-1:0] rsp_read_data,
   input wire logic              rsp_scan_done,
   input wire logic              rsp_key_change,
   input wire logic              rsp_enter_bootloader,
   input wire logic [ROW_W-1:0]  rsp_pressed_rows
);

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data) &&
      $stable(rsp_scan_done) && $stable(rsp_key_change) &&
      $stable(rsp_enter_bootloader) && $stable(rsp_pressed_rows))
      else $error("response word changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_scan_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_scan_done |-> !rsp_key_change && !rsp_enter_bootloader &&
      rsp_pressed_rows == '0)
      else $error("scan fields set without a completed scan");

   a_combo_blocks_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_enter_bootloader |-> !rsp_key_change)
      else $error("key change reported with bootloader combo");

   a_read_vs_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_data != '0 |-> !rsp_scan_done)
      else $error("read data on a scan word");

endmodule

bind key_matrix_scan_register_bank kms_checker u_kms_checker (.*);

`default_nettype wire
